// ----- sv/pending_response_match_table_unit_assert.svh -----
// assertion macros for the pending response match table
`ifndef PENDING_RESPONSE_MATCH_TABLE_UNIT_ASSERT_SVH
`define PENDING_RESPONSE_MATCH_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define PRMT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// antecedent implies consequent in the following cycle
`define PRMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRMT_ASSERT_ALWAYS(label, cond)
`define PRMT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/prmt_pkg.sv -----
`default_nettype none

package prmt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TYPE_W      = 4;
    localparam int ID_W        = 16;
    localparam int TAG_W       = 8;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_CNT_W   = 5;
    localparam int STATUS_W    = 2;

    localparam logic CMD_EXPECT   = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MATCHED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0] ptype;
        logic [ID_W-1:0]   pid;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic   vld;
        entry_t entry;
    } slot_t;

    // command broadcast to every cell
    typedef struct packed {
        logic   fire;
        logic   dispatch;
        logic   found;
        entry_t entry;
    } req_t;

    // match chain running from the newest slot down to the oldest
    typedef struct packed {
        logic             found;
        logic [TAG_W-1:0] tag;
    } hit_t;

endpackage

`default_nettype wire

// ----- sv/prmt_cell.sv -----
`default_nettype none

module prmt_cell
    import prmt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire slot_t upper,
    input  wire logic lower_vld,
    input  wire hit_t hit_in,
    output slot_t slot,
    output hit_t hit_out
);

    logic   vld_reg;
    logic   vld_next;
    entry_t ent_reg;
    entry_t ent_next;
    logic   match;
    logic   shift;
    logic   ins;

    assign match = vld_reg && req.dispatch
                   && (ent_reg.ptype == req.entry.ptype)
                   && (ent_reg.pid == req.entry.pid);

    // newest match wins: only cells with no match above may hand over their tag
    assign hit_out.found = hit_in.found | match;
    assign hit_out.tag   = hit_in.found ? hit_in.tag : ent_reg.tag;

    // cells at or above the removed slot take their upper neighbor
    assign shift = req.fire && req.dispatch && req.found && !hit_in.found;
    // first free slot takes a new entry
    assign ins   = req.fire && !req.dispatch && !vld_reg && lower_vld;

    always_comb
    begin
        vld_next = vld_reg;
        ent_next = ent_reg;
        if (shift)
        begin
            vld_next = upper.vld;
            ent_next = upper.entry;
        end
        else if (ins)
        begin
            vld_next = 1'b1;
            ent_next = req.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign slot.vld   = vld_reg;
    assign slot.entry = ent_reg;

endmodule

`default_nettype wire

// ----- sv/pending_response_match_table_unit.sv -----
// pending response match table
// input channel s_axis: tuser carries the command (expect or dispatch), tdata
// carries packet type, packet id and handler tag. an expect stores a new
// entry as the newest one unless the table is full, a dispatch removes the
// newest entry whose type and id both match and returns its tag.
// output channel m_axis: one item per accepted input item; tuser carries the
// status (inserted, matched, not found, full), tdata the matched tag and the
// number of pending entries after the command.
// the result is registered and appears in the cycle after the input item is accepted.
// throughput: one item per cycle while m_axis_tready is high; the table is a
// row of TABLE_DEPTH cells and the match chain through all of them sets the
// cycle time. a stalled receiver holds the result register; a new item is
// still taken in the cycle the waiting result leaves, otherwise s_axis_tready
// drops. reset empties the table and drops any waiting result; the entry
// payload is not cleared, empty slots are masked by their valid bits.
`default_nettype none

module pending_response_match_table_unit
    import prmt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // pkt_type[3:0], pkt_id[19:4], handler_tag[27:20]
    input  wire logic [0:0]  s_axis_tuser,  // command[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // matched_tag[7:0], entry_count[12:8]
    output logic [1:0]       m_axis_tuser   // status[1:0]
);

    `include "pending_response_match_table_unit_assert.svh"

    // input decode
    logic   in_fire;
    req_t   req;
    entry_t in_entry;

    // cell row
    slot_t [TABLE_DEPTH-1:0] slots;
    hit_t  [TABLE_DEPTH:0]   hits;
    logic  [TABLE_DEPTH-1:0] vld_vec;
    logic                    full;
    logic                    found;

    // count and result registers
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [TAG_W-1:0]    tag_reg;
    logic [TAG_W-1:0]    tag_next;

    assign s_axis_tready = !out_vld_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_entry.ptype = s_axis_tdata[3:0];
    assign in_entry.pid   = s_axis_tdata[19:4];
    assign in_entry.tag   = s_axis_tdata[27:20];

    assign req.fire     = in_fire;
    assign req.dispatch = (s_axis_tuser[0] == CMD_DISPATCH);
    assign req.found    = found;
    assign req.entry    = in_entry;

    // match chain enters at the newest slot with nothing found
    assign hits[TABLE_DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            slot_t upper_slot;
            logic  lower_valid;

            if (gi == TABLE_DEPTH - 1)
            begin : g_top
                assign upper_slot = '0;
            end
            else
            begin : g_mid
                assign upper_slot = slots[gi+1];
            end

            if (gi == 0)
            begin : g_bot
                assign lower_valid = 1'b1;
            end
            else
            begin : g_up
                assign lower_valid = slots[gi-1].vld;
            end

            prmt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .req       (req),
                .upper     (upper_slot),
                .lower_vld (lower_valid),
                .hit_in    (hits[gi+1]),
                .slot      (slots[gi]),
                .hit_out   (hits[gi])
            );

            assign vld_vec[gi] = slots[gi].vld;
        end
    endgenerate

    // valid slots are always the lowest ones
    assign full  = vld_vec[TABLE_DEPTH-1];
    assign found = hits[0].found;

    always_comb
    begin
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        tag_next     = tag_reg;
        out_vld_next = out_vld_reg;
        if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (in_fire)
        begin
            out_vld_next = 1'b1;
            tag_next     = '0;
            if (req.dispatch)
            begin
                if (found)
                begin
                    status_next = ST_MATCHED;
                    tag_next    = hits[0].tag;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            else
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        tag_reg    <= tag_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {3'b000, OUT_CNT_W'(cnt_reg), tag_reg};

    // count tracks the valid bits of the cell row
    `PRMT_ASSERT_ALWAYS(a_count_matches_row, $countones(vld_vec) == 32'(cnt_reg))
    // a full row means the count sits at the table depth
    `PRMT_ASSERT_ALWAYS(a_full_count, !full || (cnt_reg == CNT_W'(TABLE_DEPTH)))
    // an accepted item always leaves a result waiting
    `PRMT_ASSERT_NEXT(a_result_follows, in_fire, out_vld_reg)
    // an insert into a non-full table grows the count by one
    `PRMT_ASSERT_NEXT(a_insert_grows, in_fire && !req.dispatch && !full,
                      cnt_reg == $past(cnt_reg) + CNT_W'(1))

endmodule

`default_nettype wire
